FILE: hw/rtl/stsb_pkg.sv
package stsb_pkg;

  // number of timer slots
  localparam int unsigned NumSlots = 8;
  // slot index width (at least one bit)
  localparam int unsigned IdxW = (NumSlots > 1) ? $clog2(NumSlots) : 1;

  // field widths fixed by the item format
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CountW   = 32;
  localparam int unsigned TagW     = 8;
  localparam int unsigned SlotNumW = 3;
  localparam int unsigned KindW    = 2;

  // input item modes
  localparam logic [ModeW-1:0] ModeStart   = 2'd0;
  localparam logic [ModeW-1:0] ModeStop    = 2'd1;
  localparam logic [ModeW-1:0] ModeTick    = 2'd2;
  localparam logic [ModeW-1:0] ModeService = 2'd3;

  // result kinds
  localparam logic [KindW-1:0] KindOk   = 2'd0;
  localparam logic [KindW-1:0] KindFail = 2'd1;
  localparam logic [KindW-1:0] KindFire = 2'd2;

  // contents of one timer slot
  typedef struct packed {
    logic [TagW-1:0]   tag;
    logic              rpt;
    logic [CountW-1:0] count;
    logic [CountW-1:0] reload;
  } slot_t;

  // verdict of the shared slot unit for the slot under visit
  typedef struct packed {
    logic  we;
    logic  hit;
    slot_t nxt;
  } slot_op_t;

endpackage

FILE: hw/rtl/stsb_slot_unit.sv
// shared per-slot unit: free test and claim, decrement, expiry test, and reload or release
module stsb_slot_unit (
  input  logic [stsb_pkg::ModeW-1:0]  mode_i,
  input  stsb_pkg::slot_t             slot_i,
  input  logic [stsb_pkg::CountW-1:0] period_ms_i,
  input  logic [stsb_pkg::TagW-1:0]   handler_tag_i,
  input  logic                        repeat_req_i,
  output stsb_pkg::slot_op_t          op_o
);

  logic busy;
  logic at_zero;

  assign busy    = (slot_i.tag != '0);
  assign at_zero = (slot_i.count == '0);

  always_comb begin
    op_o.we  = 1'b0;
    op_o.hit = 1'b0;
    op_o.nxt = slot_i;
    case (mode_i)
      stsb_pkg::ModeStart: begin
        // claim if free
        op_o.hit        = !busy;
        op_o.we         = !busy;
        op_o.nxt.tag    = handler_tag_i;
        op_o.nxt.rpt    = repeat_req_i;
        op_o.nxt.count  = period_ms_i;
        op_o.nxt.reload = period_ms_i;
      end
      stsb_pkg::ModeTick: begin
        op_o.we        = busy && !at_zero;
        op_o.nxt.count = slot_i.count - stsb_pkg::CountW'(1);
      end
      stsb_pkg::ModeService: begin
        op_o.hit = busy && at_zero;
        op_o.we  = busy && at_zero;
        if (slot_i.rpt) begin
          op_o.nxt.count = slot_i.reload;
        end else begin
          op_o.nxt.tag = '0;
        end
      end
      default: begin
        op_o.we  = 1'b0;
        op_o.hit = 1'b0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/soft_timer_slot_bank.sv
// bank of software timer slots, each with a countdown, a reload period, a
// handler tag (nonzero means busy) and a repeat flag. a transaction is taken
// when start_i is high and busy_o is low. a stop frees its slot at once and
// leaves busy_o low. start, tick and service walk the slots one per cycle
// through a single shared slot unit: a start visits the slots up to the first
// free one, a tick visits every slot, and a service visits every slot and
// then passes through a flush state that delivers the final fire result.
// results come out as one-cycle strobes on valid_o; there is no back
// pressure, so the receiver must take every result in the cycle it shows.
// a start always gives one result with last_o set; a service gives one
// fire result per expired slot in ascending slot order, the final one with
// last_o set, or nothing when no slot has expired; stop and tick give none.
module soft_timer_slot_bank (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [stsb_pkg::ModeW-1:0]    mode_i,
  input  logic [stsb_pkg::CountW-1:0]   period_ms_i,
  input  logic [stsb_pkg::TagW-1:0]     handler_tag_i,
  input  logic                          repeat_req_i,
  input  logic [2:0]                    slot_select_i,
  output logic                          valid_o,
  output logic [stsb_pkg::KindW-1:0]    kind_o,
  output logic [stsb_pkg::SlotNumW-1:0] slot_number_o,
  output logic [stsb_pkg::TagW-1:0]     fired_tag_o,
  output logic                          last_o
);

  // sequencer states
  localparam logic [1:0] SIdle  = 2'd0;
  localparam logic [1:0] SWalk  = 2'd1;
  localparam logic [1:0] SFlush = 2'd2;

  localparam int unsigned IdxW = stsb_pkg::IdxW;

  logic [1:0] state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic last_slot;
  logic accept;

  // latched transaction
  logic [stsb_pkg::ModeW-1:0]  mode_q;
  logic [stsb_pkg::CountW-1:0] period_q;
  logic [stsb_pkg::TagW-1:0]   tag_in_q;
  logic                        rpt_in_q;

  // slot store, split so that only the busy marks and repeat flags carry a reset
  logic [stsb_pkg::TagW-1:0]   slot_tag_q    [stsb_pkg::NumSlots];
  logic                        slot_rpt_q    [stsb_pkg::NumSlots];
  logic [stsb_pkg::CountW-1:0] slot_count_q  [stsb_pkg::NumSlots];
  logic [stsb_pkg::CountW-1:0] slot_reload_q [stsb_pkg::NumSlots];

  stsb_pkg::slot_t    rd_slot;
  stsb_pkg::slot_op_t slot_op;
  logic               slot_we;
  logic               stop_clr;
  logic [IdxW-1:0]    stop_idx;

  // one fire result held back until we know whether another one follows
  logic                          pend_vld_q, pend_vld_d;
  logic [stsb_pkg::SlotNumW-1:0] pend_slot_q, pend_slot_d;
  logic [stsb_pkg::TagW-1:0]     pend_tag_q, pend_tag_d;

  // result register
  logic                          res_vld_q, res_vld_d;
  logic [stsb_pkg::KindW-1:0]    res_kind_q, res_kind_d;
  logic [stsb_pkg::SlotNumW-1:0] res_slot_q, res_slot_d;
  logic [stsb_pkg::TagW-1:0]     res_tag_q, res_tag_d;
  logic                          res_last_q, res_last_d;

  assign busy_o    = (state_q != SIdle);
  assign accept    = start_i && !busy_o;
  assign last_slot = (cnt_q == IdxW'(stsb_pkg::NumSlots - 1));

  // slot under visit
  assign rd_slot.tag    = slot_tag_q[cnt_q];
  assign rd_slot.rpt    = slot_rpt_q[cnt_q];
  assign rd_slot.count  = slot_count_q[cnt_q];
  assign rd_slot.reload = slot_reload_q[cnt_q];

  stsb_slot_unit u_slot_unit (
    .mode_i        (mode_q),
    .slot_i        (rd_slot),
    .period_ms_i   (period_q),
    .handler_tag_i (tag_in_q),
    .repeat_req_i  (rpt_in_q),
    .op_o          (slot_op)
  );

  assign slot_we = (state_q == SWalk) && slot_op.we;

  // stop of an out-of-range slot is dropped
  assign stop_idx = IdxW'(slot_select_i);
  assign stop_clr = accept && (mode_i == stsb_pkg::ModeStop) &&
                    (32'(slot_select_i) < 32'(stsb_pkg::NumSlots));

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pend_vld_d  = pend_vld_q;
    pend_slot_d = pend_slot_q;
    pend_tag_d  = pend_tag_q;
    res_vld_d   = 1'b0;
    res_kind_d  = res_kind_q;
    res_slot_d  = res_slot_q;
    res_tag_d   = res_tag_q;
    res_last_d  = res_last_q;
    case (state_q)
      SIdle: begin
        if (accept && (mode_i != stsb_pkg::ModeStop)) begin
          state_d    = SWalk;
          cnt_d      = '0;
          pend_vld_d = 1'b0;
        end
      end
      SWalk: begin
        cnt_d = cnt_q + IdxW'(1);
        case (mode_q)
          stsb_pkg::ModeStart: begin
            if (slot_op.hit) begin
              // lowest free slot claimed
              res_vld_d  = 1'b1;
              res_kind_d = stsb_pkg::KindOk;
              res_slot_d = stsb_pkg::SlotNumW'(cnt_q);
              res_tag_d  = '0;
              res_last_d = 1'b1;
              state_d    = SIdle;
            end else if (last_slot) begin
              // every slot busy
              res_vld_d  = 1'b1;
              res_kind_d = stsb_pkg::KindFail;
              res_slot_d = '0;
              res_tag_d  = '0;
              res_last_d = 1'b1;
              state_d    = SIdle;
            end
          end
          stsb_pkg::ModeTick: begin
            if (last_slot) begin
              state_d = SIdle;
            end
          end
          default: begin
            // service pass: a new fire releases the held one as not-last
            if (slot_op.hit) begin
              if (pend_vld_q) begin
                res_vld_d  = 1'b1;
                res_kind_d = stsb_pkg::KindFire;
                res_slot_d = pend_slot_q;
                res_tag_d  = pend_tag_q;
                res_last_d = 1'b0;
              end
              pend_vld_d  = 1'b1;
              pend_slot_d = stsb_pkg::SlotNumW'(cnt_q);
              pend_tag_d  = rd_slot.tag;
            end
            if (last_slot) begin
              state_d = SFlush;
            end
          end
        endcase
      end
      SFlush: begin
        // held fire is the final one of the pass
        if (pend_vld_q) begin
          res_vld_d  = 1'b1;
          res_kind_d = stsb_pkg::KindFire;
          res_slot_d = pend_slot_q;
          res_tag_d  = pend_tag_q;
          res_last_d = 1'b1;
        end
        pend_vld_d = 1'b0;
        state_d    = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      pend_vld_q <= pend_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
    pend_tag_q  <= pend_tag_d;
    res_kind_q  <= res_kind_d;
    res_slot_q  <= res_slot_d;
    res_tag_q   <= res_tag_d;
    res_last_q  <= res_last_d;
    if (accept) begin
      mode_q   <= mode_i;
      period_q <= period_ms_i;
      tag_in_q <= handler_tag_i;
      rpt_in_q <= repeat_req_i;
    end
  end

  // busy marks and repeat flags: all slots free after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < stsb_pkg::NumSlots; i++) begin
        slot_tag_q[i] <= '0;
        slot_rpt_q[i] <= 1'b0;
      end
    end else begin
      if (slot_we) begin
        slot_tag_q[cnt_q] <= slot_op.nxt.tag;
        slot_rpt_q[cnt_q] <= slot_op.nxt.rpt;
      end
      if (stop_clr) begin
        slot_tag_q[stop_idx] <= '0;
      end
    end
  end

  // counts only matter while a slot is busy, so they need no reset
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_count_q[cnt_q]  <= slot_op.nxt.count;
      slot_reload_q[cnt_q] <= slot_op.nxt.reload;
    end
  end

  assign valid_o       = res_vld_q;
  assign kind_o        = res_kind_q;
  assign slot_number_o = res_slot_q;
  assign fired_tag_o   = res_tag_q;
  assign last_o        = res_last_q;

`ifndef SYNTHESIS
  // anything but a stop makes the block busy after it is taken
  a_walk_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i != stsb_pkg::ModeStop)) |=> busy_o)
    else $error("walk did not start after transaction");

  // start results are single and always final
  a_start_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (kind_o != stsb_pkg::KindFire)) |-> last_o)
    else $error("start result without last");

  // a failed start reports slot zero and no tag
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (kind_o == stsb_pkg::KindFail)) |->
      ((slot_number_o == '0) && (fired_tag_o == '0)))
    else $error("failed start with nonzero payload");

  // only busy slots fire
  a_fire_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (kind_o == stsb_pkg::KindFire)) |-> (fired_tag_o != '0))
    else $error("fire result with zero tag");

  // no held fire result survives the end of a pass
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle) |-> !pend_vld_q)
    else $error("held fire result while idle");
`endif

endmodule
